// ===== rtl/tcae_pkg.sv =====
`timescale 1ns / 1ps

package tcae_pkg;

    localparam int COORD_BITS_DEF = 8;

    // request codes
    localparam logic [2:0] REQ_ATTR    = 3'd0;
    localparam logic [2:0] REQ_CHAR    = 3'd1;
    localparam logic [2:0] REQ_CHAR_AT = 3'd2;
    localparam logic [2:0] REQ_MOVE    = 3'd3;
    localparam logic [2:0] REQ_CLEAR   = 3'd4;

    localparam int IN_DATA_W = 32;
    localparam int IN_USER_W = 3;
    localparam int FRAME_LEN = 21;
    localparam int CNT_W     = 5;
    localparam int POS_LEN   = 10;
    localparam int TAIL_LEN  = 11;
    localparam int CLR_LEN   = 7;
    localparam int DEC_W     = 10;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_BELL_G = 8'hB7;
    localparam logic [7:0] CH_BS_G   = 8'hB0;

    localparam logic [2:0] PAL_SWAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    localparam logic [7:0] CLR_SEQ [CLR_LEN] =
        '{CH_ESC, CH_LBRACK, CH_TWO, CH_J, CH_ESC, CH_LBRACK, CH_H};

    // first field in the highest bits
    typedef struct packed {
        logic [7:0] attr;
        logic [7:0] char_code;
        logic [7:0] row;
        logic [7:0] col;
        logic [2:0] req_type;
    } t_req;

    typedef struct packed {
        logic [FRAME_LEN-1:0][7:0] data;
        logic [CNT_W-1:0]          count;
    } t_frame;

    // up to three decimal digits, most significant first
    typedef struct packed {
        logic [2:0][3:0] dig;
        logic [1:0]      len;
    } t_dec;

    function automatic t_dec to_dec(input logic [DEC_W-1:0] v);
        t_dec       d;
        logic [3:0] h;
        logic [DEC_W-1:0] r;
        logic [14:0] prod;
        logic [3:0] t;
        logic [3:0] o;
        h = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (v >= DEC_W'(i * 100)) begin
                h = 4'(i);
            end
        end
        r    = v - DEC_W'(h) * DEC_W'(100);
        // r < 100: divide by ten through the 205/2048 reciprocal
        prod = 15'(r[6:0]) * 15'd205;
        t    = prod[14:11];
        o    = 4'(r[6:0] - 7'(t) * 7'd10);
        d    = '0;
        if (v >= DEC_W'(100)) begin
            d.dig = {h, t, o};
            d.len = 2'd3;
        end else if (v >= DEC_W'(10)) begin
            d.dig = {t, o, 4'd0};
            d.len = 2'd2;
        end else begin
            d.dig = {o, 8'd0};
            d.len = 2'd1;
        end
        return d;
    endfunction

    function automatic logic [7:0] glyph(input logic [7:0] c);
        logic [7:0] g;
        if (c >= 8'h20 && c <= 8'h7E) begin
            g = c;
        end else if (c == 8'h07) begin
            g = CH_BELL_G;
        end else if (c == 8'h08) begin
            g = CH_BS_G;
        end else if (c == 8'h94) begin
            g = CH_O;
        end else if (c >= 8'hB0 && c <= 8'hB2) begin
            g = CH_HASH;
        end else if (c == 8'hB3 || c == 8'hBA) begin
            g = CH_BAR;
        end else if (c == 8'hC4 || c == 8'hCD) begin
            g = CH_DASH;
        end else if (c >= 8'hB4 && c <= 8'hDA) begin
            g = CH_PLUS;
        end else begin
            g = CH_DOT;
        end
        return g;
    endfunction

endpackage

// ===== rtl/tcae_seq_build.sv =====
`timescale 1ns / 1ps

module tcae_seq_build #(
    parameter int COORD_BITS = tcae_pkg::COORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_take,
    input  tcae_pkg::t_req  i_req,
    output tcae_pkg::t_frame o_frame
);
    import tcae_pkg::*;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    logic [COORD_BITS-1:0] r_cur_col, n_cur_col;
    logic [COORD_BITS-1:0] r_cur_row, n_cur_row;
    logic                  r_known, n_known;
    logic [3:0]            r_fore, n_fore;
    logic [2:0]            r_back, n_back;
    logic                  r_pending, n_pending;
    logic                  r_colour_mode;

    logic [COORD_BITS-1:0] x, y, col_base;
    logic                  is_char, is_pos, need_pos;
    logic [3:0]            fg_new;
    logic [2:0]            bg_new;
    t_dec                  dx, dy;
    logic [CNT_W-1:0]      lp, lt, j, k5;
    logic [POS_LEN-1:0][7:0]  pos_seg;
    logic [TAIL_LEN-1:0][7:0] tail_seg;
    logic [7:0]            gl;

    assign x = COORD_BITS'(i_req.col);
    assign y = COORD_BITS'(i_req.row);

    assign is_char = (i_req.req_type == REQ_CHAR) || (i_req.req_type == REQ_CHAR_AT);
    assign is_pos  = (i_req.req_type == REQ_CHAR_AT) || (i_req.req_type == REQ_MOVE);
    assign need_pos = is_pos && (!r_known || x != r_cur_col || y != r_cur_row);

    assign dx = to_dec(DEC_W'(x) + DEC_W'(1));
    assign dy = to_dec(DEC_W'(y) + DEC_W'(1));
    assign gl = glyph(i_req.char_code);

    always_comb begin
        if (r_colour_mode) begin
            fg_new = {1'b0, PAL_SWAP[i_req.attr[2:0]]};
            bg_new = PAL_SWAP[i_req.attr[6:4]];
        end else begin
            fg_new = (i_req.attr[2:0] != 3'd0) ? 4'd7 : 4'd0;
            bg_new = (i_req.attr[6:4] != 3'd0) ? 3'd7 : 3'd0;
        end
        fg_new[3] = i_req.attr[3];
    end

    // position segment: ESC [ row ; col H
    always_comb begin
        pos_seg = '0;
        for (int k = 0; k < POS_LEN; k++) begin
            if (k == 0) begin
                pos_seg[k] = CH_ESC;
            end else if (k == 1) begin
                pos_seg[k] = CH_LBRACK;
            end else if (k < 2 + int'(dy.len)) begin
                pos_seg[k] = CH_ZERO + 8'(dy.dig[2 - (k - 2)]);
            end else if (k == 2 + int'(dy.len)) begin
                pos_seg[k] = CH_SEMI;
            end else if (k < 3 + int'(dy.len) + int'(dx.len)) begin
                pos_seg[k] = CH_ZERO + 8'(dx.dig[2 - (k - 3 - int'(dy.len))]);
            end else if (k == 3 + int'(dy.len) + int'(dx.len)) begin
                pos_seg[k] = CH_H;
            end
        end
        lp = need_pos ? CNT_W'(4) + CNT_W'(dy.len) + CNT_W'(dx.len) : '0;
    end

    // optional colour sequence, then the glyph
    always_comb begin
        tail_seg = '0;
        if (r_pending) begin
            tail_seg[0]  = CH_ESC;
            tail_seg[1]  = CH_LBRACK;
            tail_seg[2]  = r_fore[3] ? CH_ONE : CH_ZERO;
            tail_seg[3]  = CH_SEMI;
            tail_seg[4]  = CH_THREE;
            tail_seg[5]  = CH_ZERO + 8'(r_fore[2:0]);
            tail_seg[6]  = CH_SEMI;
            tail_seg[7]  = CH_FOUR;
            tail_seg[8]  = CH_ZERO + 8'(r_back);
            tail_seg[9]  = CH_M;
            tail_seg[10] = gl;
            lt = is_char ? CNT_W'(TAIL_LEN) : '0;
        end else begin
            tail_seg[0] = gl;
            lt = is_char ? CNT_W'(1) : '0;
        end
    end

    always_comb begin
        o_frame = '0;
        j       = '0;
        k5      = '0;
        if (i_req.req_type == REQ_CLEAR) begin
            for (int k = 0; k < CLR_LEN; k++) begin
                o_frame.data[k] = CLR_SEQ[k];
            end
            o_frame.count = CNT_W'(CLR_LEN);
        end else begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                k5 = CNT_W'(k);
                j  = k5 - lp;
                if (k5 < lp) begin
                    o_frame.data[k] = pos_seg[k5[3:0]];
                end else if (j < CNT_W'(TAIL_LEN)) begin
                    o_frame.data[k] = tail_seg[j[3:0]];
                end
            end
            o_frame.count = lp + lt;
        end
    end

    always_comb begin
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_known   = r_known;
        n_fore    = r_fore;
        n_back    = r_back;
        n_pending = r_pending;
        col_base  = need_pos ? x : r_cur_col;
        case (i_req.req_type)
            REQ_ATTR: begin
                if (fg_new != r_fore || bg_new != r_back) begin
                    n_fore    = fg_new;
                    n_back    = bg_new;
                    n_pending = 1'b1;
                end
            end
            REQ_CHAR, REQ_CHAR_AT: begin
                if (need_pos) begin
                    n_cur_row = y;
                    n_known   = 1'b1;
                end
                n_cur_col = (col_base == COORD_MAX) ? col_base : col_base + 1'b1;
                n_pending = 1'b0;
            end
            REQ_MOVE: begin
                if (need_pos) begin
                    n_cur_col = x;
                    n_cur_row = y;
                    n_known   = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_cur_col = '0;
                n_cur_row = '0;
                n_known   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col     <= COORD_MAX;
            r_cur_row     <= COORD_MAX;
            r_known       <= 1'b0;
            r_fore        <= 4'd15;
            r_back        <= 3'd7;
            r_pending     <= 1'b1;
            r_colour_mode <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                r_colour_mode <= i_cfg_wr_data;
            end
            if (i_take) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                r_known   <= n_known;
                r_fore    <= n_fore;
                r_back    <= n_back;
                r_pending <= n_pending;
            end
        end
    end

endmodule

// ===== rtl/tcae_out_buf.sv =====
`timescale 1ns / 1ps

module tcae_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tcae_pkg::t_frame i_frame,
    output logic             o_load_ok,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [7:0]       o_tdata,
    output logic             o_tlast
);
    import tcae_pkg::*;

    logic [FRAME_LEN-1:0][7:0] r_buf;
    logic [CNT_W-1:0]          r_cnt;

    // free now, or its final byte leaves this cycle
    assign o_load_ok = (r_cnt == '0) || (r_cnt == CNT_W'(1) && i_tready);
    assign o_tvalid  = (r_cnt != '0);
    assign o_tdata   = r_buf[0];
    assign o_tlast   = (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_frame.count;
        end else if (o_tvalid && i_tready) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_frame.data;
        end else if (o_tvalid && i_tready) begin
            r_buf <= {8'h00, r_buf[FRAME_LEN-1:1]};
        end
    end

endmodule

// ===== rtl/text_cell_to_ansi_encoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_axis    in   tdata = col, row, char_code, attr; tuser = req_type
// m_axis    out  tdata = out_byte, tlast = last
// cfg       in   wr_data = colour_mode
//
// A request enters an input register and is expanded combinationally into a frame
// of up to 21 bytes that shifts out one byte per cycle while m_axis is ready.
// A request that sends no bytes still passes through the input register but does
// not load the output buffer. The output byte rate sets the pace.
// The next request is taken while the last byte of a frame leaves, so frames
// follow with no gap. Reset is synchronous; there is no clearing pass.

module text_cell_to_ansi_encoder #(
    parameter int COORD_BITS = tcae_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // col[7:0], row[15:8], char_code[23:16], attr[31:24]
    input  logic [tcae_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    // req_type[2:0]
    input  logic [tcae_pkg::IN_USER_W-1:0] i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import tcae_pkg::*;

    logic   r_req_vld;
    t_req   r_req;
    logic   take;
    logic   load_ok;
    t_frame frame;

    // zero-byte requests do not need the output buffer
    assign take            = r_req_vld && (load_ok || frame.count == '0);
    assign o_s_axis_tready = !r_req_vld || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_req_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_req <= t_req'({i_s_axis_tdata, i_s_axis_tuser});
        end
    end

    tcae_seq_build #(
        .COORD_BITS (COORD_BITS)
    ) u_build (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (take),
        .i_req         (r_req),
        .o_frame       (frame)
    );

    tcae_out_buf u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (take && load_ok),
        .i_frame   (frame),
        .o_load_ok (load_ok),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule
